@@ src/sha_pkg.sv @@
// shared types and constants for the sha-256 block compression core
// no dependencies; used by sha_ctrl, sha_dp and sha256_block_compress
package sha_pkg;

  localparam int CHAIN_DEPTH   = 8;
  localparam int SCHED_DEPTH   = 16;
  localparam int ROUNDS        = 64;
  localparam int EXPAND_ROUNDS = 48;

  // input function codes
  localparam logic FUNC_CHAIN = 1'b0;
  localparam logic FUNC_MSG   = 1'b1;

  // slot of the message word that kicks off a compression
  localparam logic [3:0] LAST_MSG_SLOT = 4'd15;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load_chain;
    logic       load_msg;
    logic       init_vars;
    logic       do_round;
    logic       expand;
    logic [5:0] round_idx;
    logic       add_back;
    logic       emit;
    logic [2:0] emit_idx;
  } cmd_t;

  // round constants
  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

@@ src/sha_ctrl.sv @@
// sequencer for the sha-256 core: word loads, 64 rounds, add-back, output
// depends on sha_pkg (state_t, cmd_t, constants)
module sha_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          func,
  input  logic [3:0]    word_slot,
  output logic          busy,
  output sha_pkg::cmd_t cmd
);
  import sha_pkg::*;

  state_t     state, state_next;
  logic [6:0] round_count, round_count_next;
  logic [2:0] out_idx, out_idx_next;
  logic       accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      round_count <= '0;
      out_idx     <= '0;
    end else begin
      state       <= state_next;
      round_count <= round_count_next;
      out_idx     <= out_idx_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next       = state;
    round_count_next = round_count;
    out_idx_next     = out_idx;
    cmd              = '0;
    cmd.round_idx    = round_count[5:0];
    cmd.emit_idx     = out_idx;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (func == FUNC_CHAIN) begin
            // slots past the chaining depth are dropped
            cmd.load_chain = !word_slot[3];
          end else begin
            cmd.load_msg = 1'b1;
            if (word_slot == LAST_MSG_SLOT) begin
              cmd.init_vars    = 1'b1;
              round_count_next = '0;
              state_next       = ST_ROUND;
            end
          end
        end
      end
      ST_ROUND: begin
        cmd.do_round     = 1'b1;
        cmd.expand       = (round_count < 7'(EXPAND_ROUNDS));
        round_count_next = round_count + 7'd1;
        if (round_count == 7'(ROUNDS - 1)) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add_back = 1'b1;
        out_idx_next = '0;
        state_next   = ST_OUT;
      end
      ST_OUT: begin
        cmd.emit     = 1'b1;
        out_idx_next = out_idx + 3'd1;
        if (out_idx == 3'(CHAIN_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // last round hands over to the add-back step
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && round_count == 7'(ROUNDS - 1)) |=> (state == ST_ADD))
    else $error("round sequence did not end in add-back");

  // final message word starts a fresh run at round zero
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FUNC_MSG && word_slot == LAST_MSG_SLOT)
      |=> (state == ST_ROUND && round_count == 7'd0))
    else $error("run did not start at round zero");

  // eighth word closes the output phase
  a_out_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_idx == 3'(CHAIN_DEPTH - 1)) |=> (state == ST_IDLE))
    else $error("output phase did not end after eight words");

  // loads happen only on an accepted word
  a_load_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_chain || cmd.load_msg) |-> accept)
    else $error("load without accepted word");
`endif

endmodule

@@ src/sha_dp.sv @@
// sha-256 datapath: chaining registers, 16-word schedule window, round unit,
// add-back adders and output register; depends on sha_pkg (cmd_t, round_k)
module sha_dp (
  input  logic          clk,
  input  logic          rst,
  input  sha_pkg::cmd_t cmd,
  input  logic [3:0]    word_slot,
  input  logic [31:0]   data_word,
  output logic          hash_valid,
  output logic [31:0]   hash_word,
  output logic [2:0]    hash_slot,
  output logic          last
);
  import sha_pkg::*;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  logic [31:0] chain [CHAIN_DEPTH];
  logic [31:0] sched [SCHED_DEPTH];
  logic [31:0] vars  [8];
  logic [31:0] t1, t2, w_new, w_push;

  // one round: window head is W[t]
  assign t1 = vars[7] + big_s1(vars[4]) + ((vars[4] & vars[5]) ^ (~vars[4] & vars[6]))
            + round_k(cmd.round_idx) + sched[0];
  assign t2 = big_s0(vars[0])
            + ((vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]));

  // schedule expansion; late rounds just rotate so slots end on W48..W63
  assign w_new  = small_s1(sched[14]) + sched[9] + small_s0(sched[1]) + sched[0];
  assign w_push = cmd.expand ? w_new : sched[0];

  // chaining words
  always_ff @(posedge clk) begin
    if (cmd.load_chain) begin
      chain[word_slot[2:0]] <= data_word;
    end else if (cmd.add_back) begin
      for (int i = 0; i < CHAIN_DEPTH; i++) begin
        chain[i] <= chain[i] + vars[i];
      end
    end
  end

  // message window
  always_ff @(posedge clk) begin
    if (cmd.load_msg) begin
      sched[word_slot] <= data_word;
    end else if (cmd.do_round) begin
      for (int i = 0; i < SCHED_DEPTH - 1; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[SCHED_DEPTH - 1] <= w_push;
    end
  end

  // working variables a..h
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        vars[i] <= '0;
      end
    end else if (cmd.init_vars) begin
      for (int i = 0; i < 8; i++) begin
        vars[i] <= chain[i];
      end
    end else if (cmd.do_round) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

  // output register, one word per strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_valid <= 1'b0;
    end else begin
      hash_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hash_word <= chain[cmd.emit_idx];
      hash_slot <= cmd.emit_idx;
      last      <= (cmd.emit_idx == 3'(CHAIN_DEPTH - 1));
    end
  end

`ifndef SYNTHESIS
  // a word goes out only after its strobe was commanded
  a_strobe: assert property (@(posedge clk) disable iff (rst)
    hash_valid |-> $past(cmd.emit))
    else $error("strobe without emit command");

  // the flagged word is always chaining word seven
  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    (hash_valid && last) |-> (hash_slot == 3'(CHAIN_DEPTH - 1)))
    else $error("last flag on wrong slot");

  // output words come out in slot order
  a_order: assert property (@(posedge clk) disable iff (rst)
    (hash_valid && !last) |=> (hash_valid && hash_slot == $past(hash_slot) + 3'd1))
    else $error("output words out of order");
`endif

endmodule

@@ src/sha256_block_compress.sv @@
// top level of the sha-256 block compression core
// depends on sha_pkg, sha_ctrl and sha_dp
//
//  channel  | handshake          | fields
//  ---------+--------------------+-------------------------------
//  command  | start, busy        | func, word_slot, data_word
//  result   | hash_valid strobe  | hash_word, hash_slot, last
//
// a word is taken when start is high and busy low
// message word 15 starts a run: 64 rounds at one per clock through the single
// round unit, an add-back step, then eight words H0..H7 on consecutive cycles
// synchronous reset clears the sequencer, output strobe and working variables
// the result side has no stall: each word is valid for exactly one cycle
module sha256_block_compress (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [3:0]  word_slot,
  input  logic [31:0] data_word,
  output logic        hash_valid,
  output logic [31:0] hash_word,
  output logic [2:0]  hash_slot,
  output logic        last
);
  import sha_pkg::*;

  cmd_t cmd;

  sha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .func      (func),
    .word_slot (word_slot),
    .busy      (busy),
    .cmd       (cmd)
  );

  sha_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .word_slot  (word_slot),
    .data_word  (data_word),
    .hash_valid (hash_valid),
    .hash_word  (hash_word),
    .hash_slot  (hash_slot),
    .last       (last)
  );

endmodule

@@ tb/sha256_chk.sv @@
// scoreboard for sha256_block_compress: tracks loaded words, predicts each compression
// and checks every hash word against the oldest prediction
// depends on sha_pkg for function codes and depths
module sha256_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        func,
  input  logic [3:0]  word_slot,
  input  logic [31:0] data_word,
  input  logic        hash_valid,
  input  logic [31:0] hash_word,
  input  logic [2:0]  hash_slot,
  input  logic        last,
  output int          fail_count,
  output int          words_due
);
  import sha_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  slot;
    logic        tail;
  } hash_out_t;

  localparam logic [0:63][31:0] RK = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [31:0] chain_h [CHAIN_DEPTH];
  logic [31:0] sched_w [SCHED_DEPTH];
  hash_out_t   hash_due [$];
  int          errs = 0;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  // 64 rounds over the in-place schedule window, add back, queue H0..H7
  function automatic void predict_compress();
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    hash_out_t   h;
    int          s;
    for (int i = 0; i < CHAIN_DEPTH; i++) v[i] = chain_h[i];
    for (int t = 0; t < ROUNDS; t++) begin
      s = t & 15;
      if (t >= 16)
        sched_w[s] = ssig1(sched_w[(t - 2) & 15]) + sched_w[(t - 7) & 15]
                   + ssig0(sched_w[(t - 15) & 15]) + sched_w[s];
      t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[t] + sched_w[s];
      t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < CHAIN_DEPTH; i++) begin
      chain_h[i] = chain_h[i] + v[i];
      h.word = chain_h[i];
      h.slot = 3'(i);
      h.tail = (i == CHAIN_DEPTH - 1);
      hash_due.push_back(h);
    end
  endfunction

  // check result words, then take in command words
  always @(posedge clk) begin
    hash_out_t want;
    if (rst) begin
      hash_due.delete();
    end else begin
      if (hash_valid) begin
        if (hash_due.size() == 0) begin
          errs++;
          $display("%0t: unexpected hash word: expected none, got %h slot %0d last %0b",
                   $time, hash_word, hash_slot, last);
        end else begin
          want = hash_due.pop_front();
          if (hash_word !== want.word || hash_slot !== want.slot || last !== want.tail) begin
            errs++;
            $display({"%0t: hash word mismatch: expected %h slot %0d last %0b,",
                      " got %h slot %0d last %0b"},
                     $time, want.word, want.slot, want.tail, hash_word, hash_slot, last);
          end
        end
      end
      if (start && !busy) begin
        if (func == FUNC_CHAIN) begin
          // chaining slots 8..15 do not exist and are dropped
          if (word_slot < CHAIN_DEPTH) chain_h[word_slot[2:0]] = data_word;
        end else begin
          sched_w[word_slot] = data_word;
          if (word_slot == LAST_MSG_SLOT) predict_compress();
        end
      end
    end
    fail_count <= errs;
    words_due  <= hash_due.size();
  end

endmodule

@@ tb/tb_sha256_block_compress.sv @@
// testbench top for sha256_block_compress: drives directed and random command words
// and gives the verdict; checking is done by sha256_chk
// depends on sha_pkg, sha256_chk and the rtl under src
module tb_sha256_block_compress;
  import sha_pkg::*;

  localparam logic [0:7][31:0] IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        func = FUNC_CHAIN;
  logic [3:0]  word_slot = '0;
  logic [31:0] data_word = '0;
  logic        busy;
  logic        hash_valid;
  logic [31:0] hash_word;
  logic [2:0]  hash_slot;
  logic        last;
  int          fail_count;
  int          words_due;
  int          idle_pct = 0;
  int          n_sent = 0;

  always #1 clk = ~clk;

  sha256_block_compress uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .word_slot  (word_slot),
    .data_word  (data_word),
    .hash_valid (hash_valid),
    .hash_word  (hash_word),
    .hash_slot  (hash_slot),
    .last       (last)
  );

  sha256_chk chk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .word_slot  (word_slot),
    .data_word  (data_word),
    .hash_valid (hash_valid),
    .hash_word  (hash_word),
    .hash_slot  (hash_slot),
    .last       (last),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  // word values biased toward zero, all ones and single bits
  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hffffffff;
      2: return 32'h1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  // present one word, with random idle cycles ahead of it, and wait until taken
  task automatic send_word(input logic f, input logic [3:0] s, input logic [31:0] d);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    func      <= f;
    word_slot <= s;
    data_word <= d;
    do @(posedge clk); while (busy);
    if (!(f == FUNC_CHAIN && s >= CHAIN_DEPTH)) n_sent++;
  endtask

  // stop sending and wait for every predicted hash word
  task automatic drain(input int cap);
    int w;
    start <= 1'b0;
    @(posedge clk);
    for (w = 0; w < cap && words_due != 0; w++) @(posedge clk);
  endtask

  // one block: maybe a new chaining value, a full or partial message, some noise
  task automatic send_block();
    int k;
    int n;
    k = $urandom_range(9);
    if (k < 3)
      for (int i = 0; i < CHAIN_DEPTH; i++) send_word(FUNC_CHAIN, 4'(i), pick_word());
    if ($urandom_range(3) == 0)
      send_word(FUNC_CHAIN, 4'($urandom_range(15, 8)), pick_word());
    if (k < 6) begin
      for (int i = 0; i < 15; i++) send_word(FUNC_MSG, 4'(i), pick_word());
    end else begin
      n = $urandom_range(4);
      repeat (n) send_word(FUNC_MSG, 4'($urandom_range(14)), pick_word());
    end
    if ($urandom_range(4) == 0)
      send_word(1'($urandom_range(1)), 4'($urandom_range(15)), pick_word());
    send_word(FUNC_MSG, LAST_MSG_SLOT, pick_word());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // standard initial hash value and the padded "abc" block
    idle_pct = 8;
    for (int i = 0; i < CHAIN_DEPTH; i++) send_word(FUNC_CHAIN, 4'(i), IV[i]);
    send_word(FUNC_CHAIN, 4'd15, 32'hffffffff);
    send_word(FUNC_MSG, 4'd0, 32'h61626380);
    for (int i = 1; i < 15; i++) send_word(FUNC_MSG, 4'(i), 32'h0);
    send_word(FUNC_MSG, LAST_MSG_SLOT, 32'h00000018);
    // only word 15 rewritten: runs on the expanded window left by the last block
    send_word(FUNC_MSG, LAST_MSG_SLOT, 32'hffffffff);

    // random blocks under three idle settings, fully drained between them
    while (n_sent < 75) send_block();
    drain(2000);
    idle_pct = 58;
    while (n_sent < 125) send_block();
    drain(2000);
    idle_pct = 0;
    while (n_sent < 170) send_block();
    drain(5000);
    repeat (80) @(posedge clk);

    if (fail_count == 0 && words_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
src/sha_pkg.sv
src/sha_ctrl.sv
src/sha_dp.sv
src/sha256_block_compress.sv
tb/sha256_chk.sv
tb/tb_sha256_block_compress.sv
